>>> sv/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types and constants for the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int VALUE_W  = 16;
  localparam int LETTER_W = 7;
  localparam int DIGIT_W  = 4;
  localparam int TH_RAW_W = 7;   // value / 1000 for any 16-bit value
  localparam int REM_W    = 10;  // remainder below 1000
  localparam int R2_W     = 7;   // remainder below 100

  // Reciprocal constants for exact division of the given ranges
  localparam logic [16:0] RECIP_1000 = 17'd67109;  // shift 26, 16-bit input
  localparam int          SHIFT_1000 = 26;
  localparam logic [10:0] RECIP_100  = 11'd1311;   // shift 17, 10-bit input
  localparam int          SHIFT_100  = 17;
  localparam logic [6:0]  RECIP_10   = 7'd103;     // shift 10, 7-bit input
  localparam int          SHIFT_10   = 10;

  localparam int QDEPTH = 4;
  localparam int QA_W   = 2;

  // Digit codes beyond 9: one letter still to go in a subtractive pair
  localparam logic [DIGIT_W-1:0] DIG_PEND_TEN  = 4'd10;
  localparam logic [DIGIT_W-1:0] DIG_PEND_FIVE = 4'd11;

  localparam logic [LETTER_W-1:0] LETTER_NONE = 7'h00;
  localparam logic [LETTER_W-1:0] ASC_I = 7'h49;
  localparam logic [LETTER_W-1:0] ASC_V = 7'h56;
  localparam logic [LETTER_W-1:0] ASC_X = 7'h58;
  localparam logic [LETTER_W-1:0] ASC_L = 7'h4C;
  localparam logic [LETTER_W-1:0] ASC_C = 7'h43;
  localparam logic [LETTER_W-1:0] ASC_D = 7'h44;
  localparam logic [LETTER_W-1:0] ASC_M = 7'h4D;

  localparam logic [1:0] PLACE_ONES = 2'd0;
  localparam logic [1:0] PLACE_TENS = 2'd1;
  localparam logic [1:0] PLACE_HUND = 2'd2;

  typedef struct packed {
    logic               err;
    logic [DIGIT_W-1:0] hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } rne_digits_t;

  localparam int DIG_W = $bits(rne_digits_t);

  function automatic logic [LETTER_W-1:0] one_letter(input logic [1:0] place);
    logic [LETTER_W-1:0] l;
    case (place)
      PLACE_ONES: l = ASC_I;
      PLACE_TENS: l = ASC_X;
      PLACE_HUND: l = ASC_C;
      default:    l = ASC_I;
    endcase
    return l;
  endfunction

  function automatic logic [LETTER_W-1:0] five_letter(input logic [1:0] place);
    logic [LETTER_W-1:0] l;
    case (place)
      PLACE_ONES: l = ASC_V;
      PLACE_TENS: l = ASC_L;
      PLACE_HUND: l = ASC_D;
      default:    l = ASC_V;
    endcase
    return l;
  endfunction

  function automatic logic [LETTER_W-1:0] ten_letter(input logic [1:0] place);
    logic [LETTER_W-1:0] l;
    case (place)
      PLACE_ONES: l = ASC_X;
      PLACE_TENS: l = ASC_C;
      PLACE_HUND: l = ASC_M;
      default:    l = ASC_X;
    endcase
    return l;
  endfunction

endpackage

>>> sv/rne_front.sv
// ----------------------------------------------------------------------------
// rne_front
// Accepts values, range-checks them and splits them into thousands and
// decimal digits over a six-stage pipeline with a common advance enable.
// ----------------------------------------------------------------------------
module rne_front #(
  parameter int MAX_THOUSANDS = 3,
  parameter int TH_W          = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic [rne_pkg::VALUE_W-1:0] in_value,
  output logic                      in_full,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [TH_W-1:0]           q_th,
  output rne_pkg::rne_digits_t      q_dig
);
  import rne_pkg::*;

  localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(MAX_THOUSANDS * 1000 + 999);

  logic [5:0] vld_r;
  logic       en;

  logic [VALUE_W-1:0]  v1_r;
  logic [VALUE_W-1:0]  v2_r;
  logic [TH_RAW_W-1:0] th2_r, th3_r, th4_r, th5_r, th6_r;
  logic                err2_r, err3_r, err4_r, err5_r, err6_r;
  logic [REM_W-1:0]    rem3_r, rem4_r;
  logic [DIGIT_W-1:0]  h4_r, h5_r, h6_r;
  logic [R2_W-1:0]     r2_5_r, r2_6_r;
  logic [DIGIT_W-1:0]  t6_r;

  logic [32:0]         prod1;
  logic [TH_RAW_W-1:0] th1;
  logic                err1;
  logic [VALUE_W-1:0]  rem_wide;
  logic [20:0]         prod3;
  logic [REM_W-1:0]    r2_wide;
  logic [13:0]         prod5;
  logic [R2_W-1:0]     u_wide;

  assign en      = !(vld_r[5] && q_full);
  assign in_full = !en;
  assign q_push  = vld_r[5] && !q_full;

  assign prod1    = 33'(v1_r) * 33'(RECIP_1000);
  assign th1      = prod1[SHIFT_1000 +: TH_RAW_W];
  assign err1     = (v1_r == '0) || (v1_r > MAX_VALUE);
  assign rem_wide = v2_r - (VALUE_W'(th2_r) * VALUE_W'(1000));
  assign prod3    = 21'(rem3_r) * 21'(RECIP_100);
  assign r2_wide  = rem4_r - (REM_W'(h4_r) * REM_W'(100));
  assign prod5    = 14'(r2_5_r) * 14'(RECIP_10);
  assign u_wide   = r2_6_r - (R2_W'(t6_r) * R2_W'(10));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r   <= in_value;
      v2_r   <= v1_r;
      th2_r  <= th1;
      err2_r <= err1;
      th3_r  <= th2_r;
      err3_r <= err2_r;
      rem3_r <= rem_wide[REM_W-1:0];
      th4_r  <= th3_r;
      err4_r <= err3_r;
      rem4_r <= rem3_r;
      h4_r   <= prod3[SHIFT_100 +: DIGIT_W];
      th5_r  <= th4_r;
      err5_r <= err4_r;
      h5_r   <= h4_r;
      r2_5_r <= r2_wide[R2_W-1:0];
      th6_r  <= th5_r;
      err6_r <= err5_r;
      h6_r   <= h5_r;
      r2_6_r <= r2_5_r;
      t6_r   <= prod5[SHIFT_10 +: DIGIT_W];
    end
  end

  assign q_th       = th6_r[TH_W-1:0];
  assign q_dig.err  = err6_r;
  assign q_dig.hund = h6_r;
  assign q_dig.tens = t6_r;
  assign q_dig.ones = u_wide[DIGIT_W-1:0];

endmodule

>>> sv/rne_fifo.sv
// ----------------------------------------------------------------------------
// rne_fifo
// Short word queue between the front pipeline and the letter sequencer.
// ----------------------------------------------------------------------------
module rne_fifo #(
  parameter int W = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);
  import rne_pkg::*;

  logic [W-1:0]  mem_r [QDEPTH];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QA_W:0]   cnt_r;

  assign full    = (cnt_r == (QA_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/rne_back.sv
// ----------------------------------------------------------------------------
// rne_back
// Letter sequencer: walks the thousands count and the three decimal digits
// of one entry into the result register, one letter per cycle when free.
// ----------------------------------------------------------------------------
module rne_back #(
  parameter int TH_W = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  logic [TH_W-1:0]              q_th,
  input  rne_pkg::rne_digits_t         q_dig,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [rne_pkg::LETTER_W-1:0] out_letter,
  output logic                         out_last,
  output logic                         out_error
);
  import rne_pkg::*;

  logic                busy_r;
  logic [TH_W-1:0]     m_r;
  logic [DIGIT_W-1:0]  d_r [3];
  logic                err_r;

  logic                out_vld_r;
  logic [LETTER_W-1:0] letter_r;
  logic                last_r;
  logic                error_r;

  logic                src_vld;
  logic [TH_W-1:0]     src_m;
  logic [DIGIT_W-1:0]  src_d [3];
  logic                src_err;

  logic [TH_W-1:0]     m_nxt;
  logic [DIGIT_W-1:0]  d_nxt [3];
  logic [LETTER_W-1:0] letter_nxt;
  logic                last_nxt;
  logic [1:0]          place;
  logic                fire;
  logic                can_load;

  assign src_vld  = busy_r || !q_empty;
  assign src_m    = busy_r ? m_r : q_th;
  assign src_err  = busy_r ? err_r : q_dig.err;
  assign src_d[0] = busy_r ? d_r[0] : q_dig.ones;
  assign src_d[1] = busy_r ? d_r[1] : q_dig.tens;
  assign src_d[2] = busy_r ? d_r[2] : q_dig.hund;

  assign can_load = !out_vld_r || out_pop;
  assign fire     = src_vld && can_load;
  assign q_pop    = fire && !busy_r;

  always_comb begin
    m_nxt      = src_m;
    d_nxt      = src_d;
    letter_nxt = LETTER_NONE;
    place      = PLACE_ONES;
    if (src_err) begin
      letter_nxt = LETTER_NONE;
    end else if (src_m != '0) begin
      letter_nxt = ASC_M;
      m_nxt      = src_m - 1'b1;
    end else begin
      if (src_d[2] != '0) begin
        place = PLACE_HUND;
      end else if (src_d[1] != '0) begin
        place = PLACE_TENS;
      end else begin
        place = PLACE_ONES;
      end
      case (src_d[place])
        4'd9: begin
          letter_nxt   = one_letter(place);
          d_nxt[place] = DIG_PEND_TEN;
        end
        DIG_PEND_TEN: begin
          letter_nxt   = ten_letter(place);
          d_nxt[place] = '0;
        end
        4'd4: begin
          letter_nxt   = one_letter(place);
          d_nxt[place] = DIG_PEND_FIVE;
        end
        DIG_PEND_FIVE: begin
          letter_nxt   = five_letter(place);
          d_nxt[place] = '0;
        end
        4'd5, 4'd6, 4'd7, 4'd8: begin
          letter_nxt   = five_letter(place);
          d_nxt[place] = src_d[place] - 4'd5;
        end
        4'd1, 4'd2, 4'd3: begin
          letter_nxt   = one_letter(place);
          d_nxt[place] = src_d[place] - 4'd1;
        end
        default: begin
          letter_nxt   = one_letter(place);
          d_nxt[place] = '0;
        end
      endcase
    end
    last_nxt = src_err ||
               ((m_nxt == '0) && (d_nxt[0] == '0) && (d_nxt[1] == '0) && (d_nxt[2] == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        busy_r    <= !last_nxt;
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_r      <= m_nxt;
      d_r      <= d_nxt;
      err_r    <= src_err;
      letter_r <= letter_nxt;
      last_r   <= last_nxt;
      error_r  <= src_err;
    end
  end

  assign out_empty  = !out_vld_r;
  assign out_letter = letter_r;
  assign out_last   = last_r;
  assign out_error  = error_r;

endmodule

>>> sv/roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Converts a 16-bit unsigned value into its Roman numeral, one ASCII letter
// per result word, with the final letter flagged.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  input   | in_value[15:0]                          | in_push / in_full
//  result  | out_letter[6:0], out_last, out_error    | out_pop / out_empty
//
//  An item produces 1 to MAX_THOUSANDS+12 letters, set by the sequencer,
//  which issues one letter per cycle into the result register while the
//  result is not held. A queued item follows the previous one with no gap
//  between their letters. The first letter passes through the six-stage
//  digit split, the 4-word queue and the result register.
//  Reset is synchronous; it empties the pipeline, queue and result register.
//  A held result stalls the sequencer; a full queue stalls the front and
//  raises in_full when the front's last stage holds a value.
// ----------------------------------------------------------------------------
module roman_numeral_encoder #(
  parameter int MAX_THOUSANDS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic [rne_pkg::VALUE_W-1:0]  in_value,
  output logic                         in_full,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [rne_pkg::LETTER_W-1:0] out_letter,
  output logic                         out_last,
  output logic                         out_error
);
  import rne_pkg::*;

  localparam int TH_W = $clog2(MAX_THOUSANDS + 1);
  localparam int QW   = TH_W + DIG_W;

  logic            q_push, q_pop, q_full, q_empty;
  logic [TH_W-1:0] fe_th;
  rne_digits_t     fe_dig;
  logic [QW-1:0]   q_rd;

  rne_front #(
    .MAX_THOUSANDS(MAX_THOUSANDS),
    .TH_W         (TH_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_value(in_value),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_th    (fe_th),
    .q_dig   (fe_dig)
  );

  rne_fifo #(
    .W(QW)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data({fe_th, fe_dig}),
    .pop    (q_pop),
    .rd_data(q_rd),
    .full   (q_full),
    .empty  (q_empty)
  );

  rne_back #(
    .TH_W(TH_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_th      (q_rd[QW-1:DIG_W]),
    .q_dig     (rne_digits_t'(q_rd[DIG_W-1:0])),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_letter(out_letter),
    .out_last  (out_last),
    .out_error (out_error)
  );

endmodule

>>> sv/rne_checker.sv
// ----------------------------------------------------------------------------
// rne_checker
// Port-level checks for the Roman numeral encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rne_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_full,
  input logic                         out_empty,
  input logic                         out_pop,
  input logic [rne_pkg::LETTER_W-1:0] out_letter,
  input logic                         out_last,
  input logic                         out_error
);
  import rne_pkg::*;

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("not empty and ready after reset");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_error |-> out_last && (out_letter == LETTER_NONE))
    else $error("error word not a single flagged word");

  a_letter_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_error |->
      (out_letter == ASC_I) || (out_letter == ASC_V) || (out_letter == ASC_X) ||
      (out_letter == ASC_L) || (out_letter == ASC_C) || (out_letter == ASC_D) ||
      (out_letter == ASC_M))
    else $error("illegal letter");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=>
      !out_empty && $stable(out_letter) && $stable(out_last) && $stable(out_error))
    else $error("stalled result changed");

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_letter(out_letter),
  .out_last  (out_last),
  .out_error (out_error)
);
